// File: hdl/bclr_pkg.sv
package bclr_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int OUT_IDX_W   = 10;
    localparam int POS_W       = 33;
    localparam int MAX_RESULTS = 64;
    localparam int K_W         = $clog2(MAX_RESULTS);
    localparam int DIV_CNT_W   = $clog2(POS_W + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [20:0] RST_BLOCK_SIZE   = 21'd65536;
    localparam logic [10:0] RST_MAX_RESIDENT = 11'd16;
    localparam logic [7:0]  RST_HEADER_BYTES = 8'd11;
    localparam logic [31:0] RST_DATA_END     = 32'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE,
        CFG_MAX_RESIDENT,
        CFG_HEADER_BYTES,
        CFG_DATA_END
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] start_offset;
        logic [15:0] length;
        logic [31:0] now;
    } t_in;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] block_index;
        logic                 was_hit;
        logic                 evicted_valid;
        logic [OUT_IDX_W-1:0] evicted_index;
        logic [20:0]          fill_bytes;
        logic [19:0]          copy_offset;
        logic [20:0]          copy_bytes;
        logic                 fail;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic        mark;
        logic [31:0] atime;
        logic [20:0] flen;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [20:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
        logic [20:0]      remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_DIV,
        S_RANGE,
        S_LOOKUP,
        S_SCAN,
        S_SCAN_END,
        S_EVICT,
        S_FILL,
        S_END,
        S_SERVE,
        S_EMIT
    } t_state;

endpackage

// File: hdl/block_cache_lru_residency.sv
// The time of each result beat is set mostly by the bit-serial divider
// that finds the block number and in-block offset of the current position.
// A miss with the cache full adds a scan of all MAX_BLOCKS timestamps, one memory read
// per cycle. One request is worked on at a time. After reset a clearing pass over all
// MAX_BLOCKS entries zeroes the resident marks; no request is taken during it,
// configuration writes are. Reset is synchronous, active low.
module block_cache_lru_residency (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bclr_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bclr_pkg::t_out                     o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bclr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bclr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bclr_pkg::*;

    t_state r_state, n_state;

    logic [20:0]      r_block_size;
    logic [10:0]      r_max_res;
    logic [7:0]       r_hdr;
    logic [31:0]      r_data_end;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_bstart;
    logic [POS_W-1:0] r_quo;
    logic [POS_W:0]   r_end;
    logic [15:0]      r_rem;
    logic [31:0]      r_now;
    logic [K_W-1:0]   r_k;
    logic             r_zero;
    logic [20:0]      r_remd;
    logic             r_hit;
    logic             r_evv;
    logic             r_found;
    logic             r_sv;
    logic [IDX_W-1:0] r_evi;
    logic [IDX_W-1:0] r_sidx;
    logic [IDX_W-1:0] r_cnt;
    logic [31:0]      r_best;
    logic [20:0]      r_flen;
    logic [20:0]      r_fill;
    logic [10:0]      r_count;
    t_out             r_res;
    t_out             r_out;
    logic             r_out_valid;

    t_entry           mem [MAX_BLOCKS];
    t_entry           r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W-1:0] mem_ra;
    t_entry           mem_wd;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic [20:0]      bs_eff;
    logic [IDX_W-1:0] blk_idx;
    logic             pos_lt_hdr;
    logic             out_range;
    logic [POS_W:0]   fill_sum;
    logic [20:0]      fill_cut;
    logic             stale;
    logic [20:0]      span;
    logic [15:0]      n_bytes;
    logic [15:0]      new_rem;
    logic             at_last_k;
    logic             emit;
    logic             cand;
    logic             count_inc;
    logic [IDX_W-1:0] cnt_last;

    function automatic t_out mk_fail(input logic [OUT_IDX_W-1:0] blk, input logic hit);
        t_out res;
        res               = '0;
        res.block_index   = blk;
        res.was_hit       = hit;
        res.fail          = 1'b1;
        res.last          = 1'b1;
        return res;
    endfunction

    bclr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // A block size of zero behaves as one.
    assign bs_eff     = (r_block_size == '0) ? 21'd1 : r_block_size;
    assign blk_idx    = r_quo[IDX_W-1:0];
    assign cnt_last   = IDX_W'(MAX_BLOCKS - 1);
    assign pos_lt_hdr = r_pos < POS_W'(r_hdr);
    assign out_range  = (r_pos >= POS_W'(r_data_end)) || (r_quo >= POS_W'(MAX_BLOCKS));
    assign fill_sum   = {1'b0, r_bstart} + (POS_W+1)'(bs_eff);
    assign fill_cut   = (fill_sum > (POS_W+1)'(r_data_end)) ?
                        21'(r_data_end - r_bstart[31:0]) : bs_eff;
    assign stale      = {1'b0, r_pos} >= r_end;
    assign span       = 21'(r_end - {1'b0, r_pos});
    assign n_bytes    = (span < {5'b0, r_rem}) ? span[15:0] : r_rem;
    assign new_rem    = r_rem - n_bytes;
    assign at_last_k  = r_k == K_W'(MAX_RESULTS - 1);
    assign cand       = r_sv && r_rd_data.mark && (!r_found || r_rd_data.atime < r_best);
    assign count_inc  = ((r_state == S_LOOKUP) && !r_rd_data.mark && (r_count < r_max_res))
                     || ((r_state == S_EVICT) && !r_found);
    assign mem_ra     = (r_state == S_SCAN) ? r_cnt : blk_idx;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state          = r_state;
        mem_we           = 1'b0;
        mem_wa           = blk_idx;
        mem_wd           = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_pos - POS_W'(r_hdr);
        div_req.divisor  = bs_eff;
        emit             = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                if (r_cnt == cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (pos_lt_hdr) begin
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_state = (r_zero || out_range) ? S_EMIT : S_LOOKUP;
            end
            S_LOOKUP: begin
                if (r_rd_data.mark) begin
                    n_state = S_END;
                end else if (r_count < r_max_res) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == cnt_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                mem_we       = r_found;
                mem_wa       = r_evi;
                mem_wd.mark  = 1'b0;
                mem_wd.atime = r_best;
                n_state      = S_FILL;
            end
            S_FILL: begin
                n_state = S_END;
            end
            S_END: begin
                n_state = S_SERVE;
            end
            S_SERVE: begin
                mem_we       = !stale;
                mem_wd.mark  = 1'b1;
                mem_wd.atime = r_now;
                mem_wd.flen  = r_flen;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    emit    = 1'b1;
                    n_state = r_res.last ? S_IDLE : S_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_block_size <= RST_BLOCK_SIZE;
            r_max_res    <= RST_MAX_RESIDENT;
            r_hdr        <= RST_HEADER_BYTES;
            r_data_end   <= RST_DATA_END;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_SIZE:   r_block_size <= i_cfg_data[20:0];
                    CFG_MAX_RESIDENT: r_max_res    <= i_cfg_data[10:0];
                    CFG_HEADER_BYTES: r_hdr        <= i_cfg_data[7:0];
                    CFG_DATA_END:     r_data_end   <= i_cfg_data[31:0];
                    default:          r_data_end   <= r_data_end;
                endcase
            end
            if ((r_state == S_CLEAR) || (r_state == S_SCAN)) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else if (r_state == S_LOOKUP) begin
                r_cnt <= '0;
            end
            if (count_inc) begin
                r_count <= r_count + 11'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sv   <= r_state == S_SCAN;
        r_sidx <= r_cnt;
        if (emit) begin
            r_out <= r_res;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_pos  <= POS_W'(i_in.start_offset);
                    r_rem  <= i_in.length;
                    r_now  <= i_in.now;
                    r_k    <= '0;
                    r_zero <= i_in.length == '0;
                end
            end
            S_CHK: begin
                r_res <= mk_fail('0, 1'b0);
            end
            S_DIV: begin
                r_quo  <= div_rsp.quotient;
                r_remd <= div_rsp.remainder;
            end
            S_RANGE: begin
                r_res    <= mk_fail(OUT_IDX_W'(r_quo), 1'b0);
                r_bstart <= r_pos - POS_W'(r_remd);
            end
            S_LOOKUP: begin
                r_hit   <= r_rd_data.mark;
                r_flen  <= r_rd_data.flen;
                r_fill  <= '0;
                r_evv   <= 1'b0;
                r_evi   <= '0;
                r_found <= 1'b0;
            end
            S_EVICT: begin
                r_evv <= r_found;
            end
            S_FILL: begin
                r_flen <= fill_cut;
                r_fill <= fill_cut;
            end
            S_END: begin
                r_end <= {1'b0, r_bstart} + (POS_W+1)'(r_flen);
            end
            S_SERVE: begin
                if (stale) begin
                    r_res <= mk_fail(OUT_IDX_W'(r_quo), 1'b1);
                end else begin
                    r_res.block_index   <= OUT_IDX_W'(r_quo);
                    r_res.was_hit       <= r_hit;
                    r_res.evicted_valid <= r_evv;
                    r_res.evicted_index <= OUT_IDX_W'(r_evi);
                    r_res.fill_bytes    <= r_fill;
                    r_res.copy_offset   <= r_remd[19:0];
                    r_res.copy_bytes    <= 21'(n_bytes);
                    // Bytes left after the final allowed beat end the request as a failure.
                    r_res.fail          <= (new_rem != '0) && at_last_k;
                    r_res.last          <= (new_rem == '0) || at_last_k;
                    r_pos               <= r_pos + POS_W'(n_bytes);
                    r_rem               <= new_rem;
                    r_k                 <= r_k + K_W'(1);
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
        // Oldest resident entry so far; strict compare keeps the lowest index on ties.
        if (cand) begin
            r_found <= 1'b1;
            r_best  <= r_rd_data.atime;
            r_evi   <= r_sidx;
        end
    end

    a_fail_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.fail |-> r_out.last)
        else $error("failing beat does not end the request");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.evicted_valid |-> !r_out.was_hit && (r_out.fill_bytes != '0))
        else $error("eviction reported without a fill");

    a_copy_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.was_hit && !r_out.fail |-> r_out.copy_bytes <= r_out.fill_bytes)
        else $error("copy slice exceeds filled bytes");

    a_scan_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) || (r_state == S_SCAN_END) |-> !mem_we)
        else $error("memory written during victim scan");

endmodule

// File: hdl/bclr_div.sv
module bclr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bclr_pkg::t_div_req i_req,
    output bclr_pkg::t_div_rsp o_rsp
);
    import bclr_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [POS_W-1:0]     r_quo;
    logic [20:0]          r_rem;
    logic [20:0]          r_div;
    logic [21:0]          trial;
    logic                 ge;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign trial = {r_rem, r_quo[POS_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= DIV_CNT_W'(POS_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? 21'(trial - {1'b0, r_div}) : 21'(trial);
            r_quo <= {r_quo[POS_W-2:0], ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> o_rsp.remainder < r_div)
        else $error("divider remainder not below divisor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_cnt == '0)
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_cnt) == DIV_CNT_W'(1))
        else $error("divider done without final step");

endmodule
